// File: sv/iol_pkg.sv
package iol_pkg;

    // default number of elements the list holds
    localparam int CAPACITY_DEF = 64;

    // request actions
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_INSERT     = 3'd2;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [2:0] ACT_POP_BACK   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // operation broadcast to every cell of a chain
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op OP_HOLD = 2'd0;
    localparam t_cell_op OP_INS  = 2'd1;
    localparam t_cell_op OP_DEL  = 2'd2;

endpackage

// File: sv/iol_cell.sv
module iol_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  iol_pkg::t_cell_op i_op,
    input  logic [IW-1:0]     i_idx,
    input  logic [31:0]       i_value,
    input  logic [31:0]       i_left,
    input  logic [31:0]       i_right,
    output logic [31:0]       o_data
);

    logic [31:0] r_data;
    logic [31:0] n_data;

    // insert loads the new value here or takes the left neighbor, delete takes the right one
    always_comb begin
        n_data = r_data;
        case (i_op)
            iol_pkg::OP_INS: begin
                if (i_idx == IW'(IDX)) begin
                    n_data = i_value;
                end else if (IW'(IDX) > i_idx) begin
                    n_data = i_left;
                end
            end
            iol_pkg::OP_DEL: begin
                n_data = i_right;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: sv/iol_chain.sv
module iol_chain #(
    parameter int DEPTH = iol_pkg::CAPACITY_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  iol_pkg::t_cell_op i_op,
    input  logic [IW-1:0]     i_idx,
    input  logic [31:0]       i_value,
    output logic [31:0]       o_head
);

    logic [31:0] w_data [DEPTH];

    // row of cells, each wired to its neighbors, with zero fed in at both ends
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end

        iol_cell #(
            .IW  (IW),
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (i_op),
            .i_idx   (i_idx),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k])
        );
    end

    assign o_head = w_data[0];

endmodule

// File: sv/indexed_ordered_list.sv
// indexed_ordered_list: ordered list of signed 32-bit values, up to CAPACITY entries.
// Input channel (i_in_valid / o_in_ready) carries one request item: action, position
// and value. Output channel (o_out_valid / i_out_ready) returns one result item per
// request: status, element count, front and back values (zero when the list is empty).
// The elements live in two rows of cells, one indexed from the front and one from the
// back; an insert shifts the cells from its position on in both rows, a removal shifts
// only its own row, in the same cycle, so the front and back values stay at cell zero.
// The result is registered: it is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while i_out_ready is high, as the cell rows update directly.
// The result register holds while the receiver stalls; a new request is taken in the
// same cycle as the waiting result leaves, so no cycle is lost when i_out_ready is high.
// While a result waits and i_out_ready is low, o_in_ready is low and nothing changes.
// Reset (synchronous, active low) empties the list and drops any pending result; the
// cell contents are not cleared, entries beyond the count are never shown.
module indexed_ordered_list #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_action,
    input  logic [15:0]        i_position,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [6:0]         o_element_count,
    output logic signed [31:0] o_front_value,
    output logic signed [31:0] o_back_value
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [1:0]        n_status;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic              w_pos_bad;
    iol_pkg::t_cell_op w_front_op;
    iol_pkg::t_cell_op w_back_op;
    logic [IW-1:0]     w_front_idx;
    logic [IW-1:0]     w_back_idx;
    logic [31:0]       w_front_head;
    logic [31:0]       w_back_head;

    // handshake: a new item enters when the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_pos_bad = (i_position != 16'd0) && ({1'b0, i_position} > 17'(r_count));

    // request decode into cell operations and the new count
    always_comb begin
        n_status    = iol_pkg::ST_DONE;
        n_count     = r_count;
        w_front_op  = iol_pkg::OP_HOLD;
        w_back_op   = iol_pkg::OP_HOLD;
        w_front_idx = '0;
        w_back_idx  = '0;
        case (i_action)
            iol_pkg::ACT_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = iol_pkg::ST_FULL;
                end else begin
                    w_front_op = iol_pkg::OP_INS;
                    w_back_op  = iol_pkg::OP_INS;
                    w_back_idx = r_count[IW-1:0];
                    n_count    = r_count + CW'(1);
                end
            end
            iol_pkg::ACT_PUSH_BACK: begin
                if (w_full) begin
                    n_status = iol_pkg::ST_FULL;
                end else begin
                    w_front_op  = iol_pkg::OP_INS;
                    w_back_op   = iol_pkg::OP_INS;
                    w_front_idx = r_count[IW-1:0];
                    n_count     = r_count + CW'(1);
                end
            end
            iol_pkg::ACT_INSERT: begin
                if (w_pos_bad) begin
                    n_status = iol_pkg::ST_RANGE;
                end else if (w_full) begin
                    n_status = iol_pkg::ST_FULL;
                end else begin
                    w_front_op  = iol_pkg::OP_INS;
                    w_back_op   = iol_pkg::OP_INS;
                    w_front_idx = i_position[IW-1:0];
                    w_back_idx  = r_count[IW-1:0] - i_position[IW-1:0];
                    n_count     = r_count + CW'(1);
                end
            end
            iol_pkg::ACT_POP_FRONT: begin
                if (w_empty) begin
                    n_status = iol_pkg::ST_EMPTY;
                end else begin
                    w_front_op = iol_pkg::OP_DEL;
                    n_count    = r_count - CW'(1);
                end
            end
            iol_pkg::ACT_POP_BACK: begin
                if (w_empty) begin
                    n_status = iol_pkg::ST_EMPTY;
                end else begin
                    w_back_op = iol_pkg::OP_DEL;
                    n_count   = r_count - CW'(1);
                end
            end
            default: begin
                n_status = iol_pkg::ST_DONE;
            end
        endcase
    end

    // row indexed from the front
    iol_chain #(
        .DEPTH (CAPACITY),
        .IW    (IW)
    ) u_front_chain (
        .i_clk   (i_clk),
        .i_op    (w_accept ? w_front_op : iol_pkg::OP_HOLD),
        .i_idx   (w_front_idx),
        .i_value (i_value),
        .o_head  (w_front_head)
    );

    // row indexed from the back
    iol_chain #(
        .DEPTH (CAPACITY),
        .IW    (IW)
    ) u_back_chain (
        .i_clk   (i_clk),
        .i_op    (w_accept ? w_back_op : iol_pkg::OP_HOLD),
        .i_idx   (w_back_idx),
        .i_value (i_value),
        .o_head  (w_back_head)
    );

    // count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result status
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
    end

    // result fields come from the live state, which holds while a result waits
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_element_count = 7'(r_count);
    assign o_front_value   = w_empty ? 32'sd0 : signed'(w_front_head);
    assign o_back_value    = w_empty ? 32'sd0 : signed'(w_back_head);

endmodule
